### src/bbse_pkg.sv
package bbse_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CNT_W  = COL_W + 1;
	localparam int HCNT_W = ROW_W + 1;

	localparam int PIX_W     = 8;
	localparam int WID_CFG_W = 11;
	localparam int HGT_CFG_W = 13;
	localparam int THR_W     = 11;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	localparam int WIDTH_RST  = 240;
	localparam int HEIGHT_RST = 240;
	localparam int THR_RST    = 40;

	// floor(s / 9) == (s * 3641) >> 15 for every 3x3 sum of 8-bit samples
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;

	typedef enum logic [ADDR_W-3:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} reg_idx_t;

endpackage

### src/bbse_pix_if.sv
interface bbse_pix_if;
	import bbse_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] green_sample;
	logic             is_padding;

	modport source (output valid, green_sample, is_padding, input ready);
	modport sink (input valid, green_sample, is_padding, output ready);

endinterface

### src/bbse_res_if.sv
interface bbse_res_if;
	import bbse_pkg::*;

	logic             valid;
	logic             ready;
	logic             edge_on;
	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic             frame_end;

	modport source (output valid, edge_on, out_col, out_row, frame_end, input ready);
	modport sink (input valid, edge_on, out_col, out_row, frame_end, output ready);

endinterface

### src/box_blur_sobel_edge_threshold_unit.sv
// channel  dir  handshake                 word
// pixel    in   valid / ready             green_sample[7:0], is_padding
// result   out  valid / ready             edge_on, out_col[9:0], out_row[11:0], frame_end
// config   in   psel / penable / pwrite   paddr[3:0], pwdata[31:0] -> prdata[31:0], pready
//
// One pixel word per clock, sustained while ready is high. A result word passes through
// pipeline stages s1 to s5 into the output register; the green and blur line memories
// (one read and one write port each) set the one-word-per-clock rate. Reset clears
// positions, pipeline valids and the output and skid valids; line memories and data
// registers are not cleared. ready drops only while the one-word skid register is full.
module box_blur_sobel_edge_threshold_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	bbse_pix_if.sink                      pixel,
	bbse_res_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bbse_pkg::ADDR_W-1:0]   paddr,
	input  logic [bbse_pkg::DATA_W-1:0]   pwdata,
	output logic [bbse_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import bbse_pkg::*;

	localparam int CW2    = CNT_W + 1;
	localparam int RW2    = HCNT_W + 1;
	localparam int WSUM_W = PIX_W + 2;
	localparam int SUM_W  = PIX_W + 4;
	localparam int PROD_W = SUM_W + DIV9_SHIFT;
	localparam int GRAD_W = PIX_W + 3;
	localparam int SQ_W   = 2 * GRAD_W - 2;
	localparam int MAG_W  = SQ_W + 1;
	localparam int TP1_W  = THR_W + 1;
	localparam int TSQ_W  = 2 * TP1_W;

	typedef struct packed {
		logic             act;
		logic             bmade;
		logic             bint;
		logic             rvalid;
		logic             rint;
		logic             fend;
		logic [COL_W-1:0] rcol;
		logic [ROW_W-1:0] rrow;
	} ctl_t;

	typedef struct packed {
		logic             edge_on;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             fend;
	} res_t;

	function automatic logic interior(input logic [COL_W-1:0] c, input logic [HCNT_W-1:0] r,
			input logic [CNT_W-1:0] w, input logic [HCNT_W-1:0] h);
		logic col_ok;
		logic row_ok;
		col_ok = (c != '0) && (CW2'(c) + CW2'(2) <= CW2'(w));
		row_ok = (r != '0) && (RW2'(r) + RW2'(2) <= RW2'(h));
		return col_ok && row_ok;
	endfunction

	// ---------------- configuration ----------------
	logic [WID_CFG_W-1:0] width_q;
	logic [HGT_CFG_W-1:0] height_q;
	logic [THR_W-1:0]     thr_q;
	logic [TSQ_W-1:0]     thr_sq_q;
	logic [TP1_W-1:0]     thr_p1;
	reg_idx_t             cfg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign thr_p1  = {1'b0, thr_q} + TP1_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_CFG_W'(WIDTH_RST);
			height_q <= HGT_CFG_W'(HEIGHT_RST);
			thr_q    <= THR_W'(THR_RST);
			thr_sq_q <= TSQ_W'((THR_RST + 1) * (THR_RST + 1));
		end else begin
			thr_sq_q <= TSQ_W'(thr_p1) * TSQ_W'(thr_p1);
			if (cfg_wr) begin
				case (cfg_idx)
					REG_WIDTH:  width_q  <= pwdata[WID_CFG_W-1:0];
					REG_HEIGHT: height_q <= pwdata[HGT_CFG_W-1:0];
					REG_THRESH: thr_q    <= pwdata[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			REG_THRESH: prdata = DATA_W'(thr_q);
			default:    prdata = '0;
		endcase
	end

	logic [CNT_W-1:0]  w_eff;
	logic [HCNT_W-1:0] h_eff;

	always_comb begin
		if (width_q < WID_CFG_W'(3))
			w_eff = CNT_W'(3);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = CNT_W'(MAX_WIDTH);
		else
			w_eff = CNT_W'(width_q);
		if (height_q < HGT_CFG_W'(3))
			h_eff = HCNT_W'(3);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = HCNT_W'(MAX_HEIGHT);
		else
			h_eff = HCNT_W'(height_q);
	end

	// ---------------- flow control ----------------
	logic en;
	logic in_fire;
	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;

	assign en          = !skid_v_q;
	assign pixel.ready = en;
	assign in_fire     = pixel.valid && en;

	// ---------------- positions (accept cycle) ----------------
	logic [COL_W-1:0]  in_col_q, in_col_d, blr_col_q, blr_col_d, res_col_q, res_col_d;
	logic [ROW_W-1:0]  in_row_q, in_row_d, res_row_q, res_row_d;
	logic [HCNT_W-1:0] blr_row_q, blr_row_d;
	logic              frame_done_q, frame_done_d;
	logic [CNT_W-1:0]  in_col_nx, blr_col_nx, res_col_nx;
	logic [HCNT_W-1:0] in_row_nx, res_row_ext;
	logic              eready;
	ctl_t              ctl0;

	assign res_row_ext = {1'b0, res_row_q};

	always_comb begin
		ctl0         = '0;
		ctl0.rcol    = res_col_q;
		ctl0.rrow    = res_row_q;
		eready       = 1'b0;
		in_col_d     = in_col_q;
		in_row_d     = in_row_q;
		blr_col_d    = blr_col_q;
		blr_row_d    = blr_row_q;
		res_col_d    = res_col_q;
		res_row_d    = res_row_q;
		frame_done_d = frame_done_q;
		in_col_nx    = {1'b0, in_col_q} + CNT_W'(1);
		in_row_nx    = {1'b0, in_row_q} + HCNT_W'(in_col_nx >= w_eff);
		blr_col_nx   = {1'b0, blr_col_q} + CNT_W'(1);
		res_col_nx   = {1'b0, res_col_q} + CNT_W'(1);

		if (!frame_done_q) begin
			if (!pixel.is_padding) begin
				ctl0.act   = 1'b1;
				ctl0.bmade = (in_row_q >= ROW_W'(2)) ||
					(in_row_q == ROW_W'(1) && in_col_q != '0);
				in_col_d = (in_col_nx >= w_eff) ? '0 : in_col_nx[COL_W-1:0];
				// row compare runs every non-padding sample so a smaller height ends the frame at once
				if (in_row_nx >= h_eff) begin
					frame_done_d = 1'b1;
					in_col_d     = '0;
					in_row_d     = '0;
				end else begin
					in_row_d = in_row_nx[ROW_W-1:0];
				end
			end
		end else begin
			ctl0.bmade = 1'b1;
		end

		if (ctl0.bmade) begin
			eready = (blr_row_q >= HCNT_W'(2)) ||
				(blr_row_q == HCNT_W'(1) && blr_col_q != '0);
			ctl0.bint = interior(blr_col_q, blr_row_q, w_eff, h_eff);
			blr_col_d = (blr_col_nx >= w_eff) ? '0 : blr_col_nx[COL_W-1:0];
			if (blr_col_nx >= w_eff && !(&blr_row_q))
				blr_row_d = blr_row_q + HCNT_W'(1);
			if (eready) begin
				ctl0.rvalid = 1'b1;
				ctl0.rint   = interior(res_col_q, res_row_ext, w_eff, h_eff);
				ctl0.fend   = (res_row_ext > h_eff - HCNT_W'(1)) ||
					(res_row_ext == h_eff - HCNT_W'(1) &&
					{1'b0, res_col_q} >= w_eff - CNT_W'(1));
				if (ctl0.fend) begin
					in_col_d     = '0;
					in_row_d     = '0;
					blr_col_d    = '0;
					blr_row_d    = '0;
					res_col_d    = '0;
					res_row_d    = '0;
					frame_done_d = 1'b0;
				end else if (res_col_nx >= w_eff) begin
					res_col_d = '0;
					res_row_d = res_row_q + ROW_W'(1);
				end else begin
					res_col_d = res_col_nx[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			blr_col_q    <= '0;
			blr_row_q    <= '0;
			res_col_q    <= '0;
			res_row_q    <= '0;
			frame_done_q <= 1'b0;
		end else if (in_fire) begin
			in_col_q     <= in_col_d;
			in_row_q     <= in_row_d;
			blr_col_q    <= blr_col_d;
			blr_row_q    <= blr_row_d;
			res_col_q    <= res_col_d;
			res_row_q    <= res_row_d;
			frame_done_q <= frame_done_d;
		end
	end

	// ---------------- pipeline ----------------
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= in_fire ? ctl0 : '0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// green line memory entry: {two lines up, one line up}
	logic [2*PIX_W-1:0]  gmem [MAX_WIDTH];
	logic [2*PIX_W-1:0]  gline_s1;
	logic [PIX_W-1:0]    g_s1;
	logic [COL_W-1:0]    gaddr_s1, baddr_s1, baddr_s2, baddr_s3;
	logic [WSUM_W-1:0]   cs_q [2];
	logic [WSUM_W-1:0]   colsum;
	logic [SUM_W-1:0]    sum_s2;
	logic [PROD_W-1:0]   prod;
	logic [PIX_W-1:0]    bval_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			gline_s1 <= gmem[in_col_q];
			g_s1     <= pixel.green_sample;
			gaddr_s1 <= in_col_q;
			baddr_s1 <= blr_col_q;
			if (ctl_s1.act)
				gmem[gaddr_s1] <= {gline_s1[PIX_W-1:0], g_s1};
		end
	end

	assign colsum = WSUM_W'(gline_s1[2*PIX_W-1:PIX_W]) + WSUM_W'(gline_s1[PIX_W-1:0]) +
		WSUM_W'(g_s1);

	// column sums stand in for the 3x3 green window
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s1.act) begin
				cs_q[0] <= cs_q[1];
				cs_q[1] <= colsum;
			end
			sum_s2   <= (ctl_s1.act && ctl_s1.bint) ?
				SUM_W'(cs_q[0]) + SUM_W'(cs_q[1]) + SUM_W'(colsum) : '0;
			baddr_s2 <= baddr_s1;
		end
	end

	assign prod = PROD_W'(sum_s2) * PROD_W'(DIV9_MUL);

	// blur line memory entry: {two lines up, one line up}
	logic [2*PIX_W-1:0]  bmem [MAX_WIDTH];
	logic [2*PIX_W-1:0]  bline_s2, bline_s3;
	logic [3*PIX_W-1:0]  bw_q [2];
	logic [3*PIX_W-1:0]  bnew;
	logic [WSUM_W-1:0]   sx_l, sx_r, sy_t, sy_b;
	logic signed [GRAD_W-1:0] gx_s4, gy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			bline_s2 <= bmem[baddr_s1];
			bline_s3 <= bline_s2;
			bval_s3  <= prod[DIV9_SHIFT +: PIX_W];
			baddr_s3 <= baddr_s2;
			if (ctl_s3.bmade)
				bmem[baddr_s3] <= {bline_s3[PIX_W-1:0], bval_s3};
		end
	end

	// blur window columns are {top, mid, bottom}
	assign bnew = {bline_s3, bval_s3};

	assign sx_l = WSUM_W'(bw_q[0][3*PIX_W-1:2*PIX_W]) +
		WSUM_W'({bw_q[0][2*PIX_W-1:PIX_W], 1'b0}) + WSUM_W'(bw_q[0][PIX_W-1:0]);
	assign sx_r = WSUM_W'(bnew[3*PIX_W-1:2*PIX_W]) +
		WSUM_W'({bnew[2*PIX_W-1:PIX_W], 1'b0}) + WSUM_W'(bnew[PIX_W-1:0]);
	assign sy_t = WSUM_W'(bw_q[0][3*PIX_W-1:2*PIX_W]) +
		WSUM_W'({bw_q[1][3*PIX_W-1:2*PIX_W], 1'b0}) + WSUM_W'(bnew[3*PIX_W-1:2*PIX_W]);
	assign sy_b = WSUM_W'(bw_q[0][PIX_W-1:0]) +
		WSUM_W'({bw_q[1][PIX_W-1:0], 1'b0}) + WSUM_W'(bnew[PIX_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s3.bmade) begin
				bw_q[0] <= bw_q[1];
				bw_q[1] <= bnew;
			end
			gx_s4 <= $signed({1'b0, sx_r}) - $signed({1'b0, sx_l});
			gy_s4 <= $signed({1'b0, sy_t}) - $signed({1'b0, sy_b});
		end
	end

	logic signed [2*GRAD_W-1:0] px, py;
	logic [SQ_W-1:0]            sqx_s5, sqy_s5;
	logic [MAG_W-1:0]           mag;
	res_t                       r5;

	assign px = gx_s4 * gx_s4;
	assign py = gy_s4 * gy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s5 <= px[SQ_W-1:0];
			sqy_s5 <= py[SQ_W-1:0];
		end
	end

	assign mag        = MAG_W'(sqx_s5) + MAG_W'(sqy_s5);
	assign r5.edge_on = ctl_s5.rint && (TSQ_W'(mag) >= thr_sq_q);
	assign r5.col     = ctl_s5.rcol;
	assign r5.row     = ctl_s5.rrow;
	assign r5.fend    = ctl_s5.fend;

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (ctl_s5.rvalid) begin
				if (out_v_q && !result.ready)
					skid_v_q <= 1'b1;
				else
					out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end else if (result.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s5.rvalid) begin
				if (out_v_q && !result.ready)
					skid_q <= r5;
				else
					out_q <= r5;
			end
		end else if (result.ready) begin
			out_q <= skid_q;
		end
	end

	assign result.valid     = out_v_q;
	assign result.edge_on   = out_q.edge_on;
	assign result.out_col   = out_q.col;
	assign result.out_row   = out_q.row;
	assign result.frame_end = out_q.fend;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a word while the output register is empty");

	a_done_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done_q |-> (in_col_q == '0 && in_row_q == '0))
		else $error("input position not cleared after the last sample");

	a_fend_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && ctl0.rvalid && ctl0.fend) |=>
		(res_col_q == '0 && res_row_q == '0 && blr_col_q == '0 && blr_row_q == '0 &&
		!frame_done_q))
		else $error("positions not restarted after the frame end word");
`endif

endmodule
